// File: hw/rtl/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

  localparam int FIELD_W      = 16;  // input element field width
  localparam int OUT_W        = 32;  // Q16.16 result width
  localparam int FRAC_SHIFT   = 24;  // scale of adjugate / determinant ratio
  localparam int NUM_ELEM     = 9;
  localparam int QBITS        = 33;  // quotient magnitude bits 32..0
  localparam int DIV_STAGES   = QBITS + 1;  // one overflow check + one stage per bit
  localparam int FRONT_STAGES = 6;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage
`default_nettype wire

// File: hw/rtl/m3i_if.sv
`default_nettype none
interface m3i_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_r0c0;
  logic [15:0] in_r0c1;
  logic [15:0] in_r0c2;
  logic [15:0] in_r1c0;
  logic [15:0] in_r1c1;
  logic [15:0] in_r1c2;
  logic [15:0] in_r2c0;
  logic [15:0] in_r2c1;
  logic [15:0] in_r2c2;

  modport source (output valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, input ready);
  modport sink   (input valid, in_r0c0, in_r0c1, in_r0c2, in_r1c0, in_r1c1, in_r1c2,
                  in_r2c0, in_r2c1, in_r2c2, output ready);
endinterface

interface m3i_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_r0c0;
  logic [31:0] out_r0c1;
  logic [31:0] out_r0c2;
  logic [31:0] out_r1c0;
  logic [31:0] out_r1c1;
  logic [31:0] out_r1c2;
  logic [31:0] out_r2c0;
  logic [31:0] out_r2c1;
  logic [31:0] out_r2c2;
  logic        singular;
  logic        clipped;

  modport source (output valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, singular, clipped, input ready);
  modport sink   (input valid, out_r0c0, out_r0c1, out_r0c2, out_r1c0, out_r1c1, out_r1c2,
                  out_r2c0, out_r2c1, out_r2c2, singular, clipped, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/m3i_front.sv
`default_nettype none
// Cofactors, determinant and operand magnitudes, six register stages.
module m3i_front #(
  parameter int E = 16
) (
  input  wire logic                                clk,
  input  wire logic [m3i_pkg::FRONT_STAGES-1:0]    en,
  input  wire logic [m3i_pkg::FIELD_W-1:0]         elem [m3i_pkg::NUM_ELEM],
  output logic      [2*E+24:0]                     num_mag [m3i_pkg::NUM_ELEM],
  output logic                                     neg [m3i_pkg::NUM_ELEM],
  output logic      [3*E+2:0]                      den_mag,
  output logic                                     singular
);
  import m3i_pkg::*;

  localparam int PW  = 2 * E;
  localparam int AW  = 2 * E + 1;
  localparam int DPW = 3 * E + 1;
  localparam int DW  = 3 * E + 3;

  // product operand indexes; adj[i] = p[2i] - p[2i+1]
  localparam int PA [18] = '{4, 5, 2, 1, 1, 4, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 4, 1};
  localparam int PB [18] = '{8, 7, 7, 8, 5, 2, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 0, 3};

  logic signed [E-1:0]   e_r   [NUM_ELEM];
  logic signed [PW-1:0]  p_r   [18];
  logic signed [E-1:0]   row1_r [3];
  logic signed [E-1:0]   row2_r [3];
  logic signed [AW-1:0]  adj2_r [NUM_ELEM];
  logic signed [AW-1:0]  adj3_r [NUM_ELEM];
  logic signed [AW-1:0]  adj4_r [NUM_ELEM];
  logic signed [DPW-1:0] dp_r  [3];
  logic signed [DW-1:0]  det_r;
  logic        [AW-1:0]  amag  [NUM_ELEM];

  // cofactor magnitudes for the last stage
  always_comb begin
    for (int i = 0; i < NUM_ELEM; i++) begin
      amag[i] = adj4_r[i][AW-1] ? AW'(-adj4_r[i]) : AW'(adj4_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NUM_ELEM; i++) e_r[i] <= signed'(elem[i][E-1:0]);
    end
    if (en[1]) begin
      for (int i = 0; i < 18; i++) p_r[i] <= PW'(e_r[PA[i]]) * PW'(e_r[PB[i]]);
      for (int i = 0; i < 3; i++) row1_r[i] <= e_r[i];
    end
    if (en[2]) begin
      for (int i = 0; i < NUM_ELEM; i++) adj2_r[i] <= AW'(p_r[2*i]) - AW'(p_r[2*i+1]);
      for (int i = 0; i < 3; i++) row2_r[i] <= row1_r[i];
    end
    if (en[3]) begin
      // first-row expansion: e0*C00 + e1*C01 + e2*C02
      dp_r[0] <= DPW'(row2_r[0]) * DPW'(adj2_r[0]);
      dp_r[1] <= DPW'(row2_r[1]) * DPW'(adj2_r[3]);
      dp_r[2] <= DPW'(row2_r[2]) * DPW'(adj2_r[6]);
      adj3_r  <= adj2_r;
    end
    if (en[4]) begin
      det_r  <= DW'(dp_r[0]) + DW'(dp_r[1]) + DW'(dp_r[2]);
      adj4_r <= adj3_r;
    end
    if (en[5]) begin
      for (int i = 0; i < NUM_ELEM; i++) begin
        num_mag[i] <= {amag[i], {FRAC_SHIFT{1'b0}}};
        neg[i]     <= adj4_r[i][AW-1] ^ det_r[DW-1];
      end
      den_mag  <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      singular <= (det_r == '0);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/m3i_div_lane.sv
`default_nettype none
// Restoring divider, one quotient bit per stage, fully pipelined.
// First stage sets no quotient bit; it flags a quotient of 2^33 or more.
module m3i_div_lane #(
  parameter int NW = 57,
  parameter int DW = 51
) (
  input  wire logic                                 clk,
  input  wire logic [m3i_pkg::DIV_STAGES-1:0]       en,
  input  wire logic [NW-1:0]                        num,
  input  wire logic [DW-1:0]                        den,
  input  wire logic                                 neg_in,
  output logic      [m3i_pkg::QBITS-1:0]            quo,
  output logic                                      ovf,
  output logic                                      neg_out
);
  import m3i_pkg::*;

  localparam int CW = DW + DIV_STAGES;

  logic [NW-1:0]    r_r   [DIV_STAGES];
  logic [DW-1:0]    d_r   [DIV_STAGES];
  logic [QBITS-1:0] q_r   [DIV_STAGES];
  logic             ovf_r [DIV_STAGES];
  logic             neg_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - s;
    logic [NW-1:0]    r_in;
    logic [DW-1:0]    d_in;
    logic [QBITS-1:0] q_in;
    logic             ovf_in;
    logic             n_in;
    logic [CW-1:0]    dsh;
    logic             ge;

    if (s == 0) begin : g_first
      assign r_in   = num;
      assign d_in   = den;
      assign q_in   = '0;
      assign ovf_in = 1'b0;
      assign n_in   = neg_in;
    end else begin : g_next
      assign r_in   = r_r[s-1];
      assign d_in   = d_r[s-1];
      assign q_in   = q_r[s-1];
      assign ovf_in = ovf_r[s-1];
      assign n_in   = neg_r[s-1];
    end

    assign dsh = CW'(d_in) << K;
    assign ge  = (CW'(r_in) >= dsh);

    always_ff @(posedge clk) begin
      if (en[s]) begin
        r_r[s]   <= ge ? NW'(CW'(r_in) - dsh) : r_in;
        d_r[s]   <= d_in;
        neg_r[s] <= n_in;
        if (K == QBITS) begin
          q_r[s]   <= q_in;
          ovf_r[s] <= ge;
        end else begin
          q_r[s]   <= q_in | (QBITS'(ge) << K);
          ovf_r[s] <= ovf_in;
        end
      end
    end
  end

  assign quo     = q_r[DIV_STAGES-1];
  assign ovf     = ovf_r[DIV_STAGES-1];
  assign neg_out = neg_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/m3i_merge.sv
`default_nettype none
// Signs and saturates the nine lane quotients (zero if singular), combines flags, output register.
module m3i_merge (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire logic [m3i_pkg::QBITS-1:0]      quo [m3i_pkg::NUM_ELEM],
  input  wire logic                           ovf [m3i_pkg::NUM_ELEM],
  input  wire logic                           neg [m3i_pkg::NUM_ELEM],
  input  wire logic                           singular,
  output logic      [m3i_pkg::OUT_W-1:0]      res [m3i_pkg::NUM_ELEM],
  output logic                                singular_out,
  output logic                                clipped_out
);
  import m3i_pkg::*;

  logic [OUT_W-1:0] val_nxt [NUM_ELEM];
  logic             clip_nxt;

  always_comb begin
    clip_nxt = 1'b0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      if (singular) begin
        val_nxt[i] = '0;
      end else if (neg[i]) begin
        if (ovf[i] || quo[i] > QBITS'({1'b1, {(OUT_W-1){1'b0}}})) begin
          val_nxt[i] = SAT_MIN;
          clip_nxt   = 1'b1;
        end else begin
          val_nxt[i] = OUT_W'(-quo[i]);
        end
      end else begin
        if (ovf[i] || quo[i][QBITS-1] || quo[i][OUT_W-1]) begin
          val_nxt[i] = SAT_MAX;
          clip_nxt   = 1'b1;
        end else begin
          val_nxt[i] = quo[i][OUT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res          <= val_nxt;
      singular_out <= singular;
      clipped_out  <= clip_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/matrix3_inverse.sv
`default_nettype none
// 3x3 matrix inverse by adjugate over determinant.
// in_ch: one transaction carries a 3x3 matrix of signed Q8.8 elements, row major.
// out_ch: one transaction per input, nine signed Q16.16 inverse elements,
//   truncated toward zero and saturated; clipped marks saturation, singular
//   marks a zero determinant (all elements then zero).
// Throughput: one matrix per cycle while a stage is free or out_ch is ready. Nine divider lanes run side by side.
// Pipeline: 41 register stages: 6 front stages (input, products, cofactors,
//   determinant partials, determinant, magnitudes), 34 divider stages
//   (overflow check plus one quotient bit each), 1 merge/output stage.
// Flow control: each stage holds a valid bit and advances when it is empty or
//   the stage after it advances, so bubbles collapse and in_ch.ready stays high
//   while out_ch waits, until all stages are full.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not
//   reset. ELEM_WIDTH selects how many low bits of each field are used (sign
//   extended); values above 16 act as 16.
module matrix3_inverse #(
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  m3i_in_if.sink    in_ch,
  m3i_out_if.source out_ch
);
  import m3i_pkg::*;

  localparam int E  = (ELEM_WIDTH < FIELD_W) ? ELEM_WIDTH : FIELD_W;
  localparam int NW = 2 * E + 25;
  localparam int DW = 3 * E + 3;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] en;

  // stage advance chain, output end first
  assign en[NUM_STAGES-1] = ~v_r[NUM_STAGES-1] | out_ch.ready;
  for (genvar i = 0; i < NUM_STAGES - 1; i++) begin : g_en
    assign en[i] = ~v_r[i] | en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ch.ready = en[0];

  logic [FIELD_W-1:0] elem [NUM_ELEM];
  assign elem[0] = in_ch.in_r0c0;
  assign elem[1] = in_ch.in_r0c1;
  assign elem[2] = in_ch.in_r0c2;
  assign elem[3] = in_ch.in_r1c0;
  assign elem[4] = in_ch.in_r1c1;
  assign elem[5] = in_ch.in_r1c2;
  assign elem[6] = in_ch.in_r2c0;
  assign elem[7] = in_ch.in_r2c1;
  assign elem[8] = in_ch.in_r2c2;

  logic [NW-1:0] num_mag [NUM_ELEM];
  logic          neg     [NUM_ELEM];
  logic [DW-1:0] den_mag;
  logic          sing_front;

  m3i_front #(.E(E)) u_front (
    .clk      (clk),
    .en       (en[FRONT_STAGES-1:0]),
    .elem     (elem),
    .num_mag  (num_mag),
    .neg      (neg),
    .den_mag  (den_mag),
    .singular (sing_front)
  );

  logic [QBITS-1:0] quo     [NUM_ELEM];
  logic             ovf     [NUM_ELEM];
  logic             neg_div [NUM_ELEM];

  for (genvar l = 0; l < NUM_ELEM; l++) begin : g_lane
    m3i_div_lane #(.NW(NW), .DW(DW)) u_lane (
      .clk     (clk),
      .en      (en[FRONT_STAGES +: DIV_STAGES]),
      .num     (num_mag[l]),
      .den     (den_mag),
      .neg_in  (neg[l]),
      .quo     (quo[l]),
      .ovf     (ovf[l]),
      .neg_out (neg_div[l])
    );
  end

  // singular flag rides alongside the divider stages
  logic sing_r [DIV_STAGES];
  always_ff @(posedge clk) begin
    if (en[FRONT_STAGES]) sing_r[0] <= sing_front;
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (en[FRONT_STAGES + s]) sing_r[s] <= sing_r[s-1];
    end
  end

  logic [OUT_W-1:0] res [NUM_ELEM];

  m3i_merge u_merge (
    .clk          (clk),
    .en           (en[NUM_STAGES-1]),
    .quo          (quo),
    .ovf          (ovf),
    .neg          (neg_div),
    .singular     (sing_r[DIV_STAGES-1]),
    .res          (res),
    .singular_out (out_ch.singular),
    .clipped_out  (out_ch.clipped)
  );

  assign out_ch.valid    = v_r[NUM_STAGES-1];
  assign out_ch.out_r0c0 = res[0];
  assign out_ch.out_r0c1 = res[1];
  assign out_ch.out_r0c2 = res[2];
  assign out_ch.out_r1c0 = res[3];
  assign out_ch.out_r1c1 = res[4];
  assign out_ch.out_r1c2 = res[5];
  assign out_ch.out_r2c0 = res[6];
  assign out_ch.out_r2c1 = res[7];
  assign out_ch.out_r2c2 = res[8];

endmodule
`default_nettype wire
